// File: rtl/core/sbr_pkg.sv
package sbr_pkg;

    localparam int SBR_DEPTH        = 16;
    localparam int SBR_PAYLOAD_BITS = 64;
    localparam int SBR_SEQ_W        = 64;
    localparam int SBR_DATA_W       = 64;

    localparam logic OP_PUBLISH = 1'b0;
    localparam logic OP_POLL    = 1'b1;

endpackage

// File: rtl/core/sbr_slot_store.sv
module sbr_slot_store
    import sbr_pkg::*;
#(
    parameter int DEPTH  = SBR_DEPTH,
    parameter int WIDTH  = SBR_PAYLOAD_BITS + SBR_SEQ_W,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sequenced_broadcast_ring.sv
// publish, or poll with the reader caught up: result registered in the cycle after
// acceptance, one such request per cycle unless the output stalls
// poll that reads a slot: slot memory read register, S_READ state, then output register;
// no new request is taken in S_READ, since the slot memory read is registered
// reset (synchronous, active low) clears both sequences, the slot fill state and the
// output valid; the slot memory itself is not cleared and no clearing pass runs
module sequenced_broadcast_ring
    import sbr_pkg::*;
#(
    parameter int DEPTH        = SBR_DEPTH,
    parameter int PAYLOAD_BITS = SBR_PAYLOAD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SBR_DATA_W-1:0] i_s_tdata,   // payload_in
    input  logic [0:0]            i_s_tuser,   // op
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [SBR_DATA_W-1:0] o_m_tdata,   // payload_out
    output logic [1:0]            o_m_tuser    // delivered, overrun
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int MEM_W = PAYLOAD_BITS + SBR_SEQ_W;
    localparam logic [IDX_W-1:0]     IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [SBR_SEQ_W-1:0] SEQ_LAST = '1;

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                r_state, n_state;
    logic [SBR_SEQ_W-1:0]  r_wr_seq, n_wr_seq;
    logic [SBR_SEQ_W-1:0]  r_rd_seq, n_rd_seq;
    logic [IDX_W-1:0]      r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_full, n_full;
    logic                  r_rd_valid, n_rd_valid;
    logic                  r_out_valid, n_out_valid;
    logic [SBR_DATA_W-1:0] r_out_data, n_out_data;
    logic [1:0]            r_out_user, n_out_user;

    logic                    accept;
    logic                    mem_we;
    logic                    mem_re;
    logic [MEM_W-1:0]        mem_wdata;
    logic [MEM_W-1:0]        mem_rdata;
    logic [SBR_SEQ_W-1:0]    rd_tag;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    sbr_slot_store #(
        .DEPTH (DEPTH),
        .WIDTH (MEM_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_idx),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign mem_wdata  = {r_wr_seq, i_s_tdata[PAYLOAD_BITS-1:0]};
    assign rd_tag     = mem_rdata[MEM_W-1:PAYLOAD_BITS];
    assign rd_payload = mem_rdata[PAYLOAD_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_wr_seq    = r_wr_seq;
        n_rd_seq    = r_rd_seq;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_full      = r_full;
        n_rd_valid  = r_rd_valid;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser[0] == OP_PUBLISH) begin
                        mem_we      = 1'b1;
                        n_wr_seq    = r_wr_seq + 1'b1;
                        if (r_wr_seq == SEQ_LAST || r_wr_idx == IDX_LAST) begin
                            n_wr_idx = '0;
                        end else begin
                            n_wr_idx = r_wr_idx + 1'b1;
                        end
                        if (r_wr_idx == IDX_LAST) begin
                            n_full = 1'b1;
                        end
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_user  = 2'b01;
                    end else if (r_rd_seq == r_wr_seq) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_user  = 2'b00;
                    end else begin
                        mem_re     = 1'b1;
                        n_rd_valid = r_full || (r_rd_idx < r_wr_idx);
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_rd_valid && rd_tag >= r_rd_seq) begin
                    n_out_data = SBR_DATA_W'(rd_payload);
                    n_out_user = {rd_tag != r_rd_seq, 1'b1};
                    n_rd_seq   = rd_tag + 1'b1;
                    if (rd_tag == SEQ_LAST || r_rd_idx == IDX_LAST) begin
                        n_rd_idx = '0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end else begin
                    n_out_data = '0;
                    n_out_user = 2'b00;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_seq    <= '0;
            r_rd_seq    <= '0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_seq    <= n_wr_seq;
            r_rd_seq    <= n_rd_seq;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
        r_rd_valid <= n_rd_valid;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // poll read never starts while an earlier result still waits
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("poll read overlaps a pending result");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx <= IDX_LAST) && (r_rd_idx <= IDX_LAST))
        else $error("slot index out of range");

    a_overrun_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[1]) |-> r_out_user[0])
        else $error("overrun without delivery");

    a_nodeliver_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user[0]) |-> (r_out_data == '0))
        else $error("nonzero payload on empty poll");

    a_publish_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser[0] == OP_PUBLISH) |=> (r_wr_seq == $past(r_wr_seq) + 1'b1))
        else $error("write sequence did not advance on publish");

endmodule

// File: tb/sv/tb_sequenced_broadcast_ring.sv
`timescale 1ns / 1ps

module tb_sequenced_broadcast_ring;
    import sbr_pkg::*;

    typedef struct packed {
        logic                  delivered;
        logic [SBR_DATA_W-1:0] payload;
        logic                  overrun;
    } t_ring_result;

    localparam logic [SBR_DATA_W-1:0] PAY_MASK =
        {SBR_DATA_W{1'b1}} >> (SBR_DATA_W - SBR_PAYLOAD_BITS);

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [SBR_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]            s_tuser  = OP_PUBLISH;
    logic                  m_tready = 1'b1;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [SBR_DATA_W-1:0] o_m_tdata;
    logic [1:0]            o_m_tuser;

    logic [SBR_SEQ_W-1:0]  ring_wr_seq;
    logic [SBR_SEQ_W-1:0]  ring_rd_seq;
    logic [SBR_DATA_W-1:0] slot_data [SBR_DEPTH];
    logic [SBR_SEQ_W-1:0]  slot_seq [SBR_DEPTH];
    logic                  slot_filled [SBR_DEPTH];

    t_ring_result pending_ring_results[$];
    int           error_count = 0;
    int           stall_left  = 0;
    bit           quiet       = 1'b0;

    sequenced_broadcast_ring u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // payload_in
        .i_s_tuser  (s_tuser),    // op
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),  // payload_out
        .o_m_tuser  (o_m_tuser)   // delivered, overrun
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_ring_result predict_ring_access(input logic op,
                                                         input logic [SBR_DATA_W-1:0] data);
        t_ring_result res;
        int           idx;
        res = '0;
        if (op == OP_PUBLISH) begin
            idx = int'(ring_wr_seq % SBR_DEPTH);
            slot_data[idx]   = data & PAY_MASK;
            slot_seq[idx]    = ring_wr_seq;
            slot_filled[idx] = 1'b1;
            ring_wr_seq      = ring_wr_seq + 1'b1;
            res.delivered    = 1'b1;
        end else if (ring_rd_seq != ring_wr_seq) begin
            idx = int'(ring_rd_seq % SBR_DEPTH);
            if (slot_filled[idx] && slot_seq[idx] >= ring_rd_seq) begin
                res.overrun   = (slot_seq[idx] != ring_rd_seq);
                res.payload   = slot_data[idx];
                res.delivered = 1'b1;
                ring_rd_seq   = slot_seq[idx] + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic note_error(input string what, input logic [SBR_DATA_W-1:0] exp_v,
                              input logic [SBR_DATA_W-1:0] act_v);
        error_count++;
        if (error_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    task automatic send_request(input logic op, input logic [SBR_DATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_ring_results.push_back(predict_ring_access(op, data));
    endtask

    function automatic logic [SBR_DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_ring_results.size() == 0) begin
                note_error("unexpected result", '0, o_m_tdata);
            end else begin
                want = pending_ring_results.pop_front();
                if (o_m_tuser[0] !== want.delivered)
                    note_error("delivered", want.delivered, o_m_tuser[0]);
                if (o_m_tdata !== want.payload)
                    note_error("payload_out", want.payload, o_m_tdata);
                if (o_m_tuser[1] !== want.overrun)
                    note_error("overrun", want.overrun, o_m_tuser[1]);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task automatic test_empty_poll();
        send_request(OP_POLL, rand_word());
    endtask

    task automatic test_publish_extremes();
        send_request(OP_PUBLISH, '0);
        send_request(OP_PUBLISH, '1);
        send_request(OP_PUBLISH, {SBR_DATA_W/2{2'b10}});
        send_request(OP_PUBLISH, {SBR_DATA_W/2{2'b01}});
    endtask

    task automatic test_in_order_drain();
        repeat (5) send_request(OP_POLL, rand_word());
    endtask

    task automatic test_overrun();
        for (int i = 0; i < SBR_DEPTH + 1; i++) send_request(OP_PUBLISH, rand_word());
        repeat (2) send_request(OP_POLL, '1);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int seg_len;
        int pub_pct;
        sent = 0;
        while (sent < n_items) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 1) == 0) begin
                // publish burst, then drain; long bursts overrun the reader
                seg_len = $urandom_range(0, 2 * SBR_DEPTH + 8);
                repeat (seg_len) send_request(OP_PUBLISH, rand_word());
                sent += seg_len;
                seg_len = $urandom_range(1, 2 * SBR_DEPTH);
                repeat (seg_len) send_request(OP_POLL, rand_word());
                sent += seg_len;
            end else begin
                pub_pct = 10 + 20 * $urandom_range(0, 4);
                seg_len = $urandom_range(10, 60);
                repeat (seg_len)
                    send_request(($urandom_range(0, 99) < pub_pct) ? OP_PUBLISH : OP_POLL,
                                 rand_word());
                sent += seg_len;
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        ring_wr_seq = '0;
        ring_rd_seq = '0;
        for (int i = 0; i < SBR_DEPTH; i++) begin
            slot_data[i]   = '0;
            slot_seq[i]    = '0;
            slot_filled[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_poll();
        test_publish_extremes();
        test_in_order_drain();
        test_overrun();
        test_random_traffic(1420);

        s_tvalid <= 1'b0;
        while (pending_ring_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_sequenced_broadcast_ring: done, clean");
        end else begin
            $display("tb_sequenced_broadcast_ring: done, errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_sequenced_broadcast_ring: done, errors");
        $finish;
    end

endmodule
